/* rtl/pwmr_pkg.sv */
// Shared types, constants and field layouts for the PWM ramp H-bridge drive.
package pwmr_pkg;

  localparam int DUTY_BITS = 10;
  localparam int CFG_BITS  = 10;
  // width that holds both a duty value and a step register
  localparam int SW = (DUTY_BITS > CFG_BITS) ? DUTY_BITS : CFG_BITS;

  localparam logic [DUTY_BITS-1:0] DUTY_MAX = {DUTY_BITS{1'b1}};

  localparam logic [1:0] DIR_STOP = 2'd0;
  localparam logic [1:0] DIR_CW   = 2'd1;
  localparam logic [1:0] DIR_CCW  = 2'd2;
  localparam logic [1:0] DIR_RSVD = 2'd3;

  localparam int ADDR_BITS = 4;
  localparam int DATA_BITS = 32;

  localparam logic [1:0] REG_ACCEL_STEP = 2'd0;
  localparam logic [1:0] REG_DECEL_STEP = 2'd1;
  localparam logic [1:0] REG_MIN_DUTY   = 2'd2;
  localparam logic [1:0] REG_INVERT_DIR = 2'd3;

  localparam int IN_FIELD_BITS  = DUTY_BITS + 3;
  localparam int IN_TDATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = 3 * DUTY_BITS + 2;
  localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

  typedef struct packed {
    logic [CFG_BITS-1:0] accel_step;
    logic [CFG_BITS-1:0] decel_step;
    logic [CFG_BITS-1:0] min_duty;
    logic                invert_direction;
  } cfg_t;

  // members listed from the highest bit down; first field sits highest
  typedef struct packed {
    logic                 force_stop;
    logic [1:0]           target_direction;
    logic [DUTY_BITS-1:0] target_duty;
  } in_item_t;

  typedef struct packed {
    logic [1:0]           direction_now;
    logic [DUTY_BITS-1:0] duty_now;
    logic [DUTY_BITS-1:0] left_duty;
    logic [DUTY_BITS-1:0] right_duty;
  } out_item_t;

endpackage

/* rtl/pwmr_cfg_regs.sv */
// APB-style configuration register file for the ramp drive.
module pwmr_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [pwmr_pkg::ADDR_BITS-1:0]   cfg_paddr,
  input  logic [pwmr_pkg::DATA_BITS-1:0]   cfg_pwdata,
  output logic [pwmr_pkg::DATA_BITS-1:0]   cfg_prdata,
  output logic                             cfg_pready,
  output pwmr_pkg::cfg_t                   cfg
);

  pwmr_pkg::cfg_t cfg_r;
  pwmr_pkg::cfg_t cfg_nxt;
  logic [1:0]     idx;
  logic           wr_en;

  assign idx        = cfg_paddr[3:2];
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        pwmr_pkg::REG_ACCEL_STEP: cfg_nxt.accel_step = cfg_pwdata[pwmr_pkg::CFG_BITS-1:0];
        pwmr_pkg::REG_DECEL_STEP: cfg_nxt.decel_step = cfg_pwdata[pwmr_pkg::CFG_BITS-1:0];
        pwmr_pkg::REG_MIN_DUTY:   cfg_nxt.min_duty   = cfg_pwdata[pwmr_pkg::CFG_BITS-1:0];
        pwmr_pkg::REG_INVERT_DIR: cfg_nxt.invert_direction = cfg_pwdata[0];
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.accel_step       <= pwmr_pkg::CFG_BITS'(8);
      cfg_r.decel_step       <= pwmr_pkg::CFG_BITS'(16);
      cfg_r.min_duty         <= pwmr_pkg::CFG_BITS'(100);
      cfg_r.invert_direction <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (idx)
      pwmr_pkg::REG_ACCEL_STEP: cfg_prdata = pwmr_pkg::DATA_BITS'(cfg_r.accel_step);
      pwmr_pkg::REG_DECEL_STEP: cfg_prdata = pwmr_pkg::DATA_BITS'(cfg_r.decel_step);
      pwmr_pkg::REG_MIN_DUTY:   cfg_prdata = pwmr_pkg::DATA_BITS'(cfg_r.min_duty);
      pwmr_pkg::REG_INVERT_DIR: cfg_prdata = pwmr_pkg::DATA_BITS'(cfg_r.invert_direction);
      default:                  cfg_prdata = '0;
    endcase
  end

endmodule

/* rtl/pwmr_step.sv */
// Ramp step: present duty/direction state and the per-tick update logic.
module pwmr_step (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  pwmr_pkg::cfg_t       cfg,
  input  pwmr_pkg::in_item_t   item,
  output pwmr_pkg::out_item_t  res
);

  localparam int SW = pwmr_pkg::SW;
  localparam int DB = pwmr_pkg::DUTY_BITS;

  logic [DB-1:0] duty_r;
  logic [DB-1:0] duty_nxt;
  logic [1:0]    dir_r;
  logic [1:0]    dir_nxt;

  logic [1:0]    tdir;
  logic [SW-1:0] duty_w;
  logic [SW-1:0] target_w;
  logic [SW-1:0] accel_w;
  logic [SW-1:0] decel_w;
  logic [SW-1:0] mind_w;
  logic [DB-1:0] mind;
  logic [SW-1:0] up_gap;
  logic [SW-1:0] dn_gap;
  logic [DB-1:0] ramp;
  logic [DB-1:0] rev_duty;
  logic [DB-1:0] duty_pre;
  logic [1:0]    drive;

  assign tdir     = (item.target_direction == pwmr_pkg::DIR_RSVD) ? pwmr_pkg::DIR_STOP
                                                                  : item.target_direction;
  assign duty_w   = SW'(duty_r);
  assign target_w = SW'(item.target_duty);
  assign accel_w  = SW'(cfg.accel_step);
  assign decel_w  = SW'(cfg.decel_step);
  assign mind_w   = SW'(cfg.min_duty);
  assign mind     = (mind_w > SW'(pwmr_pkg::DUTY_MAX)) ? pwmr_pkg::DUTY_MAX
                                                       : mind_w[DB-1:0];
  assign up_gap   = target_w - duty_w;
  assign dn_gap   = duty_w - target_w;

  // reversal: decelerate toward zero first
  assign rev_duty = (decel_w >= duty_w) ? '0 : DB'(duty_w - decel_w);

  // normal slew toward target, never overshooting
  always_comb begin
    if (duty_w < target_w) begin
      ramp = (accel_w >= up_gap) ? item.target_duty : DB'(duty_w + accel_w);
    end else if (duty_w > target_w) begin
      ramp = (decel_w >= dn_gap) ? item.target_duty : DB'(duty_w - decel_w);
    end else begin
      ramp = duty_r;
    end
  end

  always_comb begin
    if (item.force_stop) begin
      duty_pre = '0;
      dir_nxt  = pwmr_pkg::DIR_STOP;
    end else if (tdir != dir_r && duty_r != '0) begin
      duty_pre = rev_duty;
      dir_nxt  = (rev_duty == '0) ? tdir : dir_r;
    end else begin
      dir_nxt  = (duty_r == '0) ? tdir : dir_r;
      duty_pre = (item.target_duty != '0 && ramp != '0 && ramp < mind) ? mind : ramp;
    end
  end

  always_comb begin
    case (dir_nxt)
      pwmr_pkg::DIR_CW:  drive = cfg.invert_direction ? pwmr_pkg::DIR_CCW : pwmr_pkg::DIR_CW;
      pwmr_pkg::DIR_CCW: drive = cfg.invert_direction ? pwmr_pkg::DIR_CW : pwmr_pkg::DIR_CCW;
      default:           drive = dir_nxt;
    endcase
  end

  // brake: stop direction or zero duty clears both bridge sides
  always_comb begin
    res.right_duty = '0;
    res.left_duty  = '0;
    duty_nxt       = duty_pre;
    if (drive == pwmr_pkg::DIR_STOP || duty_pre == '0) begin
      duty_nxt = '0;
    end else if (drive == pwmr_pkg::DIR_CW) begin
      res.right_duty = duty_pre;
    end else begin
      res.left_duty = duty_pre;
    end
    res.duty_now      = duty_nxt;
    res.direction_now = dir_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_r <= '0;
      dir_r  <= pwmr_pkg::DIR_STOP;
    end else if (en) begin
      duty_r <= duty_nxt;
      dir_r  <= dir_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_duty_needs_dir: assert property (@(posedge clk) disable iff (!rst_n)
    duty_r != '0 |-> dir_r != pwmr_pkg::DIR_STOP)
    else $error("nonzero duty held with stop direction");

  a_fstop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    en && item.force_stop |=> duty_r == '0 && dir_r == pwmr_pkg::DIR_STOP)
    else $error("force stop did not clear state");

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    en |-> res.right_duty == '0 || res.left_duty == '0)
    else $error("both bridge sides driven");

  a_duty_matches: assert property (@(posedge clk) disable iff (!rst_n)
    en |-> res.duty_now == (res.right_duty | res.left_duty))
    else $error("duty_now differs from the driven side");
`endif

endmodule

/* rtl/pwm_ramp_hbridge_drive_unit.sv */
// Top level of the PWM ramp H-bridge drive: stream ports, pipeline registers, config port.
// One transaction on the input stream is one ramp tick and yields exactly one result
// transaction. A tick passes an input register, then the slew/brake logic, then the output
// register, and one tick is accepted per cycle sustained while out_tready holds, since the
// duty/direction state is written at the same edge that loads the result. The input side
// keeps accepting while a result waits, until both registers are full. Configuration
// (accel_step, decel_step, min_duty, invert_direction at byte addresses 0, 4, 8, 12)
// should be written only with no tick in flight.
module pwm_ramp_hbridge_drive_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // fields from bit 0: target_duty, target_direction, force_stop, zero pad
  input  logic [pwmr_pkg::IN_TDATA_BITS-1:0]   in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // fields from bit 0: right_duty, left_duty, duty_now, direction_now
  output logic [pwmr_pkg::OUT_TDATA_BITS-1:0]  out_tdata,
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [pwmr_pkg::ADDR_BITS-1:0]       cfg_paddr,
  input  logic [pwmr_pkg::DATA_BITS-1:0]       cfg_pwdata,
  output logic [pwmr_pkg::DATA_BITS-1:0]       cfg_prdata,
  output logic                                 cfg_pready
);

  pwmr_pkg::cfg_t      cfg;
  pwmr_pkg::in_item_t  in_r;
  pwmr_pkg::out_item_t res;
  pwmr_pkg::out_item_t out_r;

  logic s1_valid_r;
  logic s1_valid_nxt;
  logic out_valid_r;
  logic out_valid_nxt;
  logic in_fire;
  logic adv;

  assign adv       = s1_valid_r & (~out_valid_r | out_tready);
  assign in_tready = ~s1_valid_r | adv;
  assign in_fire   = in_tvalid & in_tready;

  assign s1_valid_nxt  = in_fire ? 1'b1 : (adv ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = adv ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_r <= in_tdata[pwmr_pkg::IN_FIELD_BITS-1:0];
    end
    if (adv) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = pwmr_pkg::OUT_TDATA_BITS'(out_r);

  pwmr_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  pwmr_step u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .cfg   (cfg),
    .item  (in_r),
    .res   (res)
  );

endmodule
